@@ rtl/lobm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book matcher package
// Shared types, codes and sizes for the order matching block.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int BookSlots = 32;
  localparam int SlotBits  = $clog2(BookSlots);
  localparam int CntBits   = $clog2(BookSlots + 1);

  typedef enum logic [1:0] {
    FUNC_LIMIT  = 2'd0,
    FUNC_MARKET = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_MODIFY = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_TRADE     = 3'd0,
    ST_RESTED    = 3'd1,
    ST_COMPLETE  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BOOK_FULL = 3'd4,
    ST_CANCELLED = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        side;
    logic [31:0] order_ref;
    logic [31:0] limit_price;
    logic [31:0] quantity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] buy_order_id;
    logic [31:0] sell_order_id;
    logic [31:0] trade_price;
    logic [31:0] exec_qty;
    logic        last;
  } out_item_t;

  // Classified request passed from the front end to the engine.
  typedef struct packed {
    logic        is_add;
    logic        market;
    logic        is_cancel;
    logic        side;
    logic [31:0] order_ref;
    logic [31:0] limit_price;
    logic [31:0] quantity;
  } req_t;

endpackage

@@ rtl/limit_order_book_matcher_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limit order book matcher
// Price-time priority matching over a 32-slot resting order table.
// ----------------------------------------------------------------------------
// Each result of an add request follows a scan of all 32 slots; a cancel or
// modify first scans the slots for its id, and a modify that finds its order
// then runs as an add. The engine holds one request at a time and takes the
// next only after the last result of the current one has been taken.
// Reset: synchronous active-low; clears valid bits, queue and arrival count.
module limit_order_book_matcher_unit import lobm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic req_valid, req_take, res_valid;
  req_t req;

  lobm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_item(in_item), .req_valid(req_valid), .req(req), .req_take(req_take)
  );

  lobm_engine u_engine (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req(req),
    .req_take(req_take), .res_valid(res_valid), .res(out_item), .res_take(out_pop)
  );

  assign out_empty = !res_valid;

endmodule

@@ rtl/lobm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book matcher front end
// Accepts requests, classifies them and keeps a two-entry request queue.
// ----------------------------------------------------------------------------
module lobm_front import lobm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output logic     req_valid,
  output req_t     req,
  input  logic     req_take
);

  req_t       q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r;
  logic       wr_r;
  req_t       cls;
  logic       push_ok;
  logic       pop_ok;

  // Classify the incoming item.
  always_comb begin
    cls.is_add      = (in_item.func == FUNC_LIMIT) || (in_item.func == FUNC_MARKET);
    cls.market      = (in_item.func == FUNC_MARKET);
    cls.is_cancel   = (in_item.func == FUNC_CANCEL);
    cls.side        = in_item.side;
    cls.order_ref   = in_item.order_ref;
    cls.limit_price = in_item.limit_price;
    cls.quantity    = in_item.quantity;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rd_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = req_take && req_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_r] <= cls;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push_ok) wr_r <= !wr_r;
      if (pop_ok)  rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

endmodule

@@ rtl/lobm_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book matcher engine
// Holds the slot table and carries out one request at a time by slot scans.
// ----------------------------------------------------------------------------
module lobm_engine import lobm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  input  req_t      req,
  output logic      req_take,
  output logic      res_valid,
  output out_item_t res,
  input  logic      res_take
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_FILL  = 7'b0001000,
    S_FREE  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Slot table: valid bits in flops, payload per slot.
  logic [BookSlots-1:0] valid_r;
  logic                 sside_r  [BookSlots];
  logic [31:0]          sprice_r [BookSlots];
  logic [31:0]          sqty_r   [BookSlots];
  logic [31:0]          sid_r    [BookSlots];
  logic [31:0]          sseq_r   [BookSlots];
  logic [31:0]          arrival_r;

  // Request registers.
  logic        side_r, market_r, cancel_r, add_r;
  logic [31:0] id_r, price_r, rem_r;
  logic [CntBits-1:0]  idx_r;
  logic [CntBits-1:0]  nfill_r;
  logic        best_ok_r;
  logic [SlotBits-1:0] best_r;
  logic [31:0] best_price_r, best_age_r;
  logic        free_ok_r;
  logic [SlotBits-1:0] free_r;

  // Result register.
  logic      res_valid_r;
  out_item_t res_r;
  out_item_t res_nxt;
  logic      res_load;

  logic [SlotBits-1:0] ix;
  logic [31:0] age;
  logic        elig, better, idm;
  logic [31:0] fill_q;
  logic        last_slot;
  logic        do_trade, do_done;

  assign ix        = idx_r[SlotBits-1:0];
  assign age       = arrival_r - sseq_r[ix];
  assign last_slot = (idx_r == CntBits'(BookSlots - 1));
  assign req_take  = (state_r == S_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // One slot compared per cycle for the best opposite order and for the id match.
  always_comb begin
    elig = valid_r[ix] && (sside_r[ix] != side_r) &&
           (market_r || (side_r ? (sprice_r[ix] >= price_r) : (sprice_r[ix] <= price_r)));
    if (!best_ok_r) begin
      better = 1'b1;
    end else if (sprice_r[ix] != best_price_r) begin
      better = side_r ? (sprice_r[ix] > best_price_r) : (sprice_r[ix] < best_price_r);
    end else begin
      better = age > best_age_r;
    end
    idm = valid_r[ix] && (sid_r[ix] == id_r) && (!best_ok_r || age < best_age_r);
  end

  assign fill_q   = (rem_r < sqty_r[best_r]) ? rem_r : sqty_r[best_r];
  assign do_trade = (rem_r != '0) && best_ok_r && (nfill_r != CntBits'(BookSlots));
  assign do_done  = (rem_r == '0) || market_r;

  // Result to load: a trade or the final status of the request.
  always_comb begin
    res_nxt      = '0;
    res_nxt.last = 1'b1;
    res_load     = 1'b0;
    if (state_r == S_FILL) begin
      res_load = 1'b1;
      if (do_trade) begin
        res_nxt.status        = ST_TRADE;
        res_nxt.last          = 1'b0;
        res_nxt.buy_order_id  = side_r ? sid_r[best_r] : id_r;
        res_nxt.sell_order_id = side_r ? id_r : sid_r[best_r];
        res_nxt.trade_price   = sprice_r[best_r];
        res_nxt.exec_qty      = fill_q;
      end else if (do_done) begin
        res_nxt.status   = ST_COMPLETE;
        res_nxt.exec_qty = rem_r;
      end else if (free_ok_r) begin
        res_nxt.status   = ST_RESTED;
        res_nxt.exec_qty = rem_r;
      end else begin
        res_nxt.status   = ST_BOOK_FULL;
        res_nxt.exec_qty = rem_r;
      end
    end else if (state_r == S_FREE) begin
      if (!best_ok_r) begin
        res_load       = 1'b1;
        res_nxt.status = ST_NOT_FOUND;
      end else if (cancel_r) begin
        res_load       = 1'b1;
        res_nxt.status = ST_CANCELLED;
      end
    end
  end

  // Sequencer state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (req_valid) state_nxt = req.is_add ? S_SCAN : S_FIND;
      S_FIND: if (last_slot) state_nxt = S_FREE;
      S_SCAN: if (last_slot) state_nxt = S_FILL;
      S_FILL: state_nxt = S_WAIT;
      S_FREE: state_nxt = S_WAIT;
      S_EMIT: state_nxt = S_WAIT;
      S_WAIT: if (!res_valid_r || res_take) state_nxt = add_r ? S_SCAN : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_load) begin
      res_valid_r <= 1'b1;
    end else if (res_valid_r && res_take) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  // Engine datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      arrival_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            side_r    <= req.side;
            market_r  <= req.market;
            cancel_r  <= req.is_cancel;
            add_r     <= req.is_add;
            id_r      <= req.order_ref;
            price_r   <= req.limit_price;
            rem_r     <= req.quantity;
            idx_r     <= '0;
            nfill_r   <= '0;
            best_ok_r <= 1'b0;
            free_ok_r <= 1'b0;
          end
        end
        S_FIND: begin
          if (idm) begin
            best_ok_r  <= 1'b1;
            best_r     <= ix;
            best_age_r <= age;
          end
          idx_r <= last_slot ? '0 : idx_r + 1'b1;
        end
        S_SCAN: begin
          if (elig && better) begin
            best_ok_r    <= 1'b1;
            best_r       <= ix;
            best_price_r <= sprice_r[ix];
            best_age_r   <= age;
          end
          if (!valid_r[ix] && !free_ok_r) begin
            free_ok_r <= 1'b1;
            free_r    <= ix;
          end
          idx_r <= last_slot ? '0 : idx_r + 1'b1;
        end
        S_FILL: begin
          if (do_trade) begin
            // Trade against the best resting order.
            sqty_r[best_r]      <= sqty_r[best_r] - fill_q;
            if (sqty_r[best_r] == fill_q) valid_r[best_r] <= 1'b0;
            rem_r   <= rem_r - fill_q;
            nfill_r <= nfill_r + 1'b1;
          end else if (do_done) begin
            add_r           <= 1'b0;
          end else if (free_ok_r) begin
            valid_r[free_r]  <= 1'b1;
            sside_r[free_r]  <= side_r;
            sprice_r[free_r] <= price_r;
            sqty_r[free_r]   <= rem_r;
            sid_r[free_r]    <= id_r;
            sseq_r[free_r]   <= arrival_r;
            arrival_r        <= arrival_r + 1'b1;
            add_r            <= 1'b0;
          end else begin
            add_r           <= 1'b0;
          end
        end
        S_FREE: begin
          // Cancel or modify after the id lookup.
          if (!best_ok_r) begin
            add_r        <= 1'b0;
          end else begin
            valid_r[best_r] <= 1'b0;
            if (cancel_r) begin
              add_r        <= 1'b0;
            end else begin
              side_r    <= sside_r[best_r];
              market_r  <= 1'b0;
              add_r     <= 1'b1;
              best_ok_r <= 1'b0;
            end
          end
        end
        S_EMIT: ;
        S_WAIT: begin
          // Wait for the result register, then go on or finish.
          if ((!res_valid_r || res_take) && add_r) begin
            idx_r     <= '0;
            best_ok_r <= 1'b0;
            free_ok_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book matcher testbench
// Drives add, market, cancel and modify requests into the matcher, keeps its
// own copy of the resting order table to predict trades and final statuses,
// and compares every result transfer field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import lobm_pkg::*;

  localparam int PendDepth = 1024;
  localparam int ExpDepth  = 4096;
  localparam int HoldLen   = 3000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  always #4 clk = ~clk;

  limit_order_book_matcher_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_item(in_item), .out_empty(out_empty), .out_pop(out_pop),
    .out_item(out_item)
  );

  // Shadow copy of the resting order table.
  logic        bk_valid [BookSlots];
  logic        bk_side  [BookSlots];
  logic [31:0] bk_price [BookSlots];
  logic [31:0] bk_qty   [BookSlots];
  logic [31:0] bk_id    [BookSlots];
  logic [31:0] bk_seq   [BookSlots];
  logic [31:0] arrivals;

  // Pending requests in a plain array and expected results in a ring, each with its own indices.
  in_item_t  pend_buf [PendDepth];
  int        pend_wr = 0;
  int        pend_rd = 0;
  out_item_t exp_buf [ExpDepth];
  int        exp_wr = 0;
  int        exp_rd = 0;

  int        error_count = 0;
  int        send_idle = 0;
  int        recv_stall = 0;
  bit        hold_go = 1'b0;
  int        held = 0;

  // Full as seen at the last rising edge, for deciding a completed transfer.
  logic in_full_q = 1'b1;
  always @(posedge clk) in_full_q <= in_full;

  task automatic report(input string msg);
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void post(input status_t st, input logic [31:0] b,
                               input logic [31:0] s, input logic [31:0] p,
                               input logic [31:0] q, input logic last);
    out_item_t r;
    r.status = st; r.buy_order_id = b; r.sell_order_id = s;
    r.trade_price = p; r.exec_qty = q; r.last = last;
    exp_buf[exp_wr % ExpDepth] = r;
    exp_wr++;
  endfunction

  // Best eligible opposite order: best price, then oldest arrival.
  function automatic int best_match(input logic side, input bit mkt,
                                    input logic [31:0] price);
    int best = -1;
    bit better;
    for (int i = 0; i < BookSlots; i++) begin
      if (!bk_valid[i] || bk_side[i] == side) continue;
      if (!mkt && side == 1'b0 && bk_price[i] > price) continue;
      if (!mkt && side == 1'b1 && bk_price[i] < price) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (bk_price[i] != bk_price[best])
        better = side ? (bk_price[i] > bk_price[best]) : (bk_price[i] < bk_price[best]);
      else
        better = (arrivals - bk_seq[i]) > (arrivals - bk_seq[best]);
      if (better) best = i;
    end
    return best;
  endfunction

  function automatic int lookup_id(input logic [31:0] id);
    int f = -1;
    for (int i = 0; i < BookSlots; i++) begin
      if (!bk_valid[i] || bk_id[i] != id) continue;
      if (f < 0 || (arrivals - bk_seq[i]) < (arrivals - bk_seq[f])) f = i;
    end
    return f;
  endfunction

  function automatic void run_add(input logic side, input bit mkt,
                                  input logic [31:0] id,
                                  input logic [31:0] price,
                                  input logic [31:0] qty);
    logic [31:0] rem = qty;
    logic [31:0] t;
    int n = 0;
    int m;
    while (rem != 0 && n < BookSlots) begin
      m = best_match(side, mkt, price);
      if (m < 0) break;
      t = (rem < bk_qty[m]) ? rem : bk_qty[m];
      if (side == 1'b0) post(ST_TRADE, id, bk_id[m], bk_price[m], t, 1'b0);
      else post(ST_TRADE, bk_id[m], id, bk_price[m], t, 1'b0);
      n++;
      bk_qty[m] -= t;
      rem -= t;
      if (bk_qty[m] == 0) bk_valid[m] = 1'b0;
    end
    if (rem == 0 || mkt) begin
      post(ST_COMPLETE, '0, '0, '0, rem, 1'b1);
      return;
    end
    for (int i = 0; i < BookSlots; i++) begin
      if (!bk_valid[i]) begin
        bk_valid[i] = 1'b1; bk_side[i] = side; bk_price[i] = price;
        bk_qty[i] = rem; bk_id[i] = id; bk_seq[i] = arrivals;
        arrivals++;
        post(ST_RESTED, '0, '0, '0, rem, 1'b1);
        return;
      end
    end
    post(ST_BOOK_FULL, '0, '0, '0, rem, 1'b1);
  endfunction

  function automatic void predict_request(input in_item_t it);
    int s;
    if (it.func == FUNC_LIMIT || it.func == FUNC_MARKET) begin
      run_add(it.side, it.func == FUNC_MARKET, it.order_ref, it.limit_price,
              it.quantity);
      return;
    end
    s = lookup_id(it.order_ref);
    if (s < 0) begin
      post(ST_NOT_FOUND, '0, '0, '0, '0, 1'b1);
      return;
    end
    bk_valid[s] = 1'b0;
    if (it.func == FUNC_CANCEL) post(ST_CANCELLED, '0, '0, '0, '0, 1'b1);
    else run_add(bk_side[s], 1'b0, it.order_ref, it.limit_price, it.quantity);
  endfunction

  // Driver: offers the head of the pending requests, idling at random.
  always @(negedge clk) begin
    if (rst_n && in_push && !in_full_q) begin
      predict_request(in_item);
      pend_rd++;
    end
    if (pend_rd != pend_wr && ($urandom_range(99) >= send_idle)) begin
      in_push <= 1'b1;
      in_item <= pend_buf[pend_rd];
    end else begin
      in_push <= 1'b0;
      in_item <= 71'({$urandom, $urandom, $urandom});
    end
  end

  // Receiver: one long hold-off counted here, else random stalls.
  always @(negedge clk) begin
    if (hold_go && held < HoldLen) begin
      held++;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (exp_rd == exp_wr) begin
        report("result with nothing expected");
      end else begin
        out_item_t e;
        e = exp_buf[exp_rd % ExpDepth];
        exp_rd++;
        if (out_item.status !== e.status)
          report($sformatf("status %0d, wanted %0d", out_item.status, e.status));
        if (out_item.buy_order_id !== e.buy_order_id)
          report($sformatf("buy id %h, wanted %h", out_item.buy_order_id,
                           e.buy_order_id));
        if (out_item.sell_order_id !== e.sell_order_id)
          report($sformatf("sell id %h, wanted %h", out_item.sell_order_id,
                           e.sell_order_id));
        if (out_item.trade_price !== e.trade_price)
          report($sformatf("price %h, wanted %h", out_item.trade_price,
                           e.trade_price));
        if (out_item.exec_qty !== e.exec_qty)
          report($sformatf("qty %h, wanted %h", out_item.exec_qty, e.exec_qty));
        if (out_item.last !== e.last)
          report($sformatf("last %b, wanted %b", out_item.last, e.last));
      end
    end
  end

  function automatic in_item_t mk(input func_t f, input logic sd,
                                  input logic [31:0] id, input logic [31:0] p,
                                  input logic [31:0] q);
    in_item_t it;
    it.func = f; it.side = sd; it.order_ref = id; it.limit_price = p;
    it.quantity = q;
    return it;
  endfunction

  function automatic void queue_req(input in_item_t it);
    pend_buf[pend_wr] = it;
    pend_wr++;
  endfunction

  // Random request biased towards a crowded book near one price.
  function automatic in_item_t rand_request();
    int k = $urandom_range(99);
    func_t f;
    logic [31:0] p, q, id;
    if (k < 55) f = FUNC_LIMIT;
    else if (k < 70) f = FUNC_MARKET;
    else if (k < 85) f = FUNC_CANCEL;
    else f = FUNC_MODIFY;
    id = ($urandom_range(9) == 0) ? $urandom : $urandom_range(40);
    p = ($urandom_range(19) == 0) ? $urandom : 32'd1000 + $urandom_range(8);
    case ($urandom_range(9))
      0: q = $urandom;
      1: q = 32'd0;
      default: q = $urandom_range(1, 60);
    endcase
    return mk(f, 1'($urandom_range(1)), id, p, q);
  endfunction

  task automatic wait_drain();
    while (pend_rd != pend_wr || exp_rd != exp_wr)
      @(posedge clk);
  endtask

  // Stimulus
  initial begin
    for (int i = 0; i < BookSlots; i++) bk_valid[i] = 1'b0;
    arrivals = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: extremes, every request kind, a filled book and its overflow.
    queue_req(mk(FUNC_CANCEL, 1'b0, 32'd5, 32'd0, 32'd0));
    queue_req(mk(FUNC_MODIFY, 1'b1, 32'hFFFF_FFFF, 32'd1, 32'd1));
    queue_req(mk(FUNC_LIMIT, 1'b0, 32'd1, 32'd100, 32'd0));
    queue_req(mk(FUNC_MARKET, 1'b0, 32'd2, 32'd0, 32'd10));
    queue_req(mk(FUNC_LIMIT, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_req(mk(FUNC_LIMIT, 1'b1, 32'd3, 32'd100, 32'd5));
    queue_req(mk(FUNC_LIMIT, 1'b1, 32'd3, 32'd100, 32'd7));
    queue_req(mk(FUNC_LIMIT, 1'b0, 32'd4, 32'd0, 32'd9));
    queue_req(mk(FUNC_MODIFY, 1'b0, 32'd3, 32'd99, 32'd4));
    queue_req(mk(FUNC_MODIFY, 1'b1, 32'd4, 32'd99, 32'd2));
    queue_req(mk(FUNC_LIMIT, 1'b0, 32'd6, 32'd101, 32'd20));
    queue_req(mk(FUNC_MARKET, 1'b0, 32'd7, 32'd0, 32'hFFFF_FFFF));
    queue_req(mk(FUNC_CANCEL, 1'b1, 32'd6, 32'd0, 32'd0));
    queue_req(mk(FUNC_CANCEL, 1'b0, 32'd6, 32'd0, 32'd0));
    for (int i = 0; i < BookSlots + 2; i++)
      queue_req(mk(FUNC_LIMIT, 1'b0, 32'd100 + i, 32'd10 + i, 32'd1));
    queue_req(mk(FUNC_MARKET, 1'b1, 32'd8, 32'd0, 32'd40));
    wait_drain();

    // Random phases with different idling patterns.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 66; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 66; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      if (ph == 0) hold_go = 1'b1;
      for (int n = 0; n < 93; n++) queue_req(rand_request());
      wait_drain();
    end
    repeat (200) @(posedge clk);
    if (error_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Timeout
  initial begin
    #50ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/lobm_pkg.sv
rtl/lobm_front.sv
rtl/lobm_engine.sv
rtl/limit_order_book_matcher_unit.sv
verif/tb_top.sv
